FILE: rtl/hsvg_pkg.sv
// ----------------------------------------------------------------------------
// hsvg_pkg: shared types and constants for the hsv to grb converter
// Hue sector codes, reciprocal constants and the stage-to-stage payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvg_pkg;

	// hue sector: which channel holds chroma and which one ramps
	typedef enum logic [2:0] {
		SEC_RISE_G = 3'd0,  // red = chroma, green rises
		SEC_FALL_R = 3'd1,  // green = chroma, red falls
		SEC_RISE_B = 3'd2,  // green = chroma, blue rises
		SEC_FALL_G = 3'd3,  // blue = chroma, green falls
		SEC_RISE_R = 3'd4,  // blue = chroma, red rises
		SEC_FALL_B = 3'd5   // red = chroma, blue falls
	} sector_t;

	// upper hue bound of each sector
	localparam logic [7:0] HUE_END_0 = 8'd43;
	localparam logic [7:0] HUE_END_1 = 8'd85;
	localparam logic [7:0] HUE_END_2 = 8'd128;
	localparam logic [7:0] HUE_END_3 = 8'd171;
	localparam logic [7:0] HUE_END_4 = 8'd213;
	localparam logic [7:0] HUE_END_5 = 8'd255;
	// start of the rising sectors
	localparam logic [7:0] HUE_START_2 = 8'd86;
	localparam logic [7:0] HUE_START_4 = 8'd172;

	// x / 43 and x / 42 as (x * RECIP) >> RECIP_SHIFT, exact for x <= 255 * 43
	localparam int unsigned RECIP_SHIFT = 19;
	localparam logic [13:0] RECIP_43    = 14'd12193;
	localparam logic [13:0] RECIP_42    = 14'd12484;

	typedef struct packed {
		sector_t     sector;
		logic [5:0]  offset;
		logic [7:0]  chroma;
		logic [7:0]  base;
		logic [7:0]  value;
	} chroma_t;

	typedef struct packed {
		sector_t     sector;
		logic [7:0]  ramp;
		logic [7:0]  base;
		logic [7:0]  value;
	} ramp_t;

endpackage

`default_nettype wire

FILE: rtl/hsvg_pix_if.sv
// ----------------------------------------------------------------------------
// hsvg_pix_if: hsv pixel channel
// Valid/ready channel carrying one hue, saturation, brightness word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvg_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/hsvg_grb_if.sv
// ----------------------------------------------------------------------------
// hsvg_grb_if: grb pixel channel
// Valid/ready channel carrying one green, red, blue word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsvg_grb_if;
	logic       valid;
	logic       ready;
	logic [7:0] green;
	logic [7:0] red;
	logic [7:0] blue;

	modport source (output valid, output green, output red, output blue, input ready);
	modport sink (input valid, input green, input red, input blue, output ready);
endinterface

`default_nettype wire

FILE: rtl/hsvg_chroma.sv
// ----------------------------------------------------------------------------
// hsvg_chroma: chroma and hue sector stages
// Stage 1 multiplies brightness by saturation and decodes the hue sector,
// stage 2 divides the product by 255 and forms the grey base.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvg_chroma (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             valid,
	input  wire logic [7:0]       hue,
	input  wire logic [7:0]       saturation,
	input  wire logic [7:0]       brightness,
	output logic                  valid_s2,
	output hsvg_pkg::chroma_t     data_s2
);

	hsvg_pkg::sector_t sector;
	logic [7:0]        offset_full;

	logic              valid_s1;
	logic [15:0]       prod_s1;
	hsvg_pkg::sector_t sector_s1;
	logic [5:0]        offset_s1;
	logic [7:0]        value_s1;

	logic [15:0]       div_sum;
	logic [7:0]        chroma;

	always_comb begin
		if (hue <= hsvg_pkg::HUE_END_0) begin
			sector      = hsvg_pkg::SEC_RISE_G;
			offset_full = hue;
		end else if (hue <= hsvg_pkg::HUE_END_1) begin
			sector      = hsvg_pkg::SEC_FALL_R;
			offset_full = hsvg_pkg::HUE_END_1 - hue;
		end else if (hue <= hsvg_pkg::HUE_END_2) begin
			sector      = hsvg_pkg::SEC_RISE_B;
			offset_full = hue - hsvg_pkg::HUE_START_2;
		end else if (hue <= hsvg_pkg::HUE_END_3) begin
			sector      = hsvg_pkg::SEC_FALL_G;
			offset_full = hsvg_pkg::HUE_END_3 - hue;
		end else if (hue <= hsvg_pkg::HUE_END_4) begin
			sector      = hsvg_pkg::SEC_RISE_R;
			offset_full = hue - hsvg_pkg::HUE_START_4;
		end else begin
			sector      = hsvg_pkg::SEC_FALL_B;
			offset_full = hsvg_pkg::HUE_END_5 - hue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1   <= {8'd0, brightness} * {8'd0, saturation};
			sector_s1 <= sector;
			offset_s1 <= offset_full[5:0];
			value_s1  <= brightness;
		end
	end

	// exact divide by 255 for the 8-bit by 8-bit product
	assign div_sum = prod_s1 + {8'd0, prod_s1[15:8]} + 16'd1;
	assign chroma  = div_sum[15:8];

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2.sector <= sector_s1;
			data_s2.offset <= offset_s1;
			data_s2.chroma <= chroma;
			data_s2.base   <= value_s1 - chroma;
			data_s2.value  <= value_s1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/hsvg_ramp.sv
// ----------------------------------------------------------------------------
// hsvg_ramp: ramp channel stages
// Stage 3 multiplies chroma by the sector offset, stage 4 divides by 43 or
// 42 through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvg_ramp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              valid_s2,
	input  wire hsvg_pkg::chroma_t data_s2,
	output logic                   valid_s4,
	output hsvg_pkg::ramp_t        data_s4
);

	logic              valid_s3;
	logic [13:0]       prod_s3;
	hsvg_pkg::sector_t sector_s3;
	logic [7:0]        base_s3;
	logic [7:0]        value_s3;

	logic [13:0]       recip;
	logic [27:0]       scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3   <= {6'd0, data_s2.chroma} * {8'd0, data_s2.offset};
			sector_s3 <= data_s2.sector;
			base_s3   <= data_s2.base;
			value_s3  <= data_s2.value;
		end
	end

	// red ramps are divided by 42, the others by 43
	always_comb begin
		case (sector_s3) inside
			hsvg_pkg::SEC_FALL_R, hsvg_pkg::SEC_RISE_R: recip = hsvg_pkg::RECIP_42;
			default:                                    recip = hsvg_pkg::RECIP_43;
		endcase
	end

	assign scaled = {14'd0, prod_s3} * {14'd0, recip};

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s4.sector <= sector_s3;
			data_s4.ramp   <= scaled[hsvg_pkg::RECIP_SHIFT +: 8];
			data_s4.base   <= base_s3;
			data_s4.value  <= value_s3;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/hsvg_mix.sv
// ----------------------------------------------------------------------------
// hsvg_mix: channel assembly and output register
// Adds the grey base to the ramp and routes value, ramp and base to green,
// red and blue by hue sector.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvg_mix (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            valid_s4,
	input  wire hsvg_pkg::ramp_t data_s4,
	output logic                 valid_s5,
	output logic [7:0]           green_s5,
	output logic [7:0]           red_s5,
	output logic [7:0]           blue_s5
);

	logic [7:0] ramp_full;
	logic [7:0] green;
	logic [7:0] red;
	logic [7:0] blue;

	// chroma plus base is the brightness itself
	assign ramp_full = data_s4.ramp + data_s4.base;

	always_comb begin
		unique case (data_s4.sector)
			hsvg_pkg::SEC_RISE_G: begin
				red = data_s4.value; green = ramp_full; blue = data_s4.base;
			end
			hsvg_pkg::SEC_FALL_R: begin
				red = ramp_full; green = data_s4.value; blue = data_s4.base;
			end
			hsvg_pkg::SEC_RISE_B: begin
				red = data_s4.base; green = data_s4.value; blue = ramp_full;
			end
			hsvg_pkg::SEC_FALL_G: begin
				red = data_s4.base; green = ramp_full; blue = data_s4.value;
			end
			hsvg_pkg::SEC_RISE_R: begin
				red = ramp_full; green = data_s4.base; blue = data_s4.value;
			end
			default: begin
				red = data_s4.value; green = data_s4.base; blue = ramp_full;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			green_s5 <= green;
			red_s5   <= red;
			blue_s5  <= blue;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/hsv_to_grb_8bit_top.sv
// ----------------------------------------------------------------------------
// hsv_to_grb_8bit_top: 8-bit hsv to grb pixel converter
// Five-stage pipeline turning one hsv pixel into green, red and blue.
// ----------------------------------------------------------------------------
// usage:
//   pix carries hue, saturation and brightness; grb returns green, red, blue.
//   a word is taken on pix when valid and ready are both high, and one grb
//   word comes out for every pix word, in order.
// path: an accepted word moves through the s1, s2, s3, s4 and s5 registers;
//   grb.valid rises once it reaches s5, the output register.
// throughput: one pixel per clock unless the output stalls; the stages are the
//   brightness by saturation multiply, the divide by 255, the chroma by offset
//   multiply, the reciprocal divide by 43 or 42, and the channel mux into the
//   output register.
// stall: all stages advance together; while grb.valid is high and grb.ready
//   low the pipeline holds and pix.ready drops, so nothing is lost or sent
//   twice. holes in the pipeline move on with the words and are not squeezed out.
// reset: arst_n clears every valid bit at once; the block can take a word as
//   soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_grb_8bit_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	hsvg_pix_if.sink    pix,
	hsvg_grb_if.source  grb
);

	logic              adv;
	logic              valid_s2;
	hsvg_pkg::chroma_t data_s2;
	logic              valid_s4;
	hsvg_pkg::ramp_t   data_s4;

	// pipeline moves whenever the output register is empty or being read
	assign adv       = !grb.valid || grb.ready;
	assign pix.ready = adv;

	hsvg_chroma u_chroma (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.valid      (pix.valid),
		.hue        (pix.hue),
		.saturation (pix.saturation),
		.brightness (pix.brightness),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2)
	);

	hsvg_ramp u_ramp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4)
	);

	hsvg_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s4 (valid_s4),
		.data_s4  (data_s4),
		.valid_s5 (grb.valid),
		.green_s5 (grb.green),
		.red_s5   (grb.red),
		.blue_s5  (grb.blue)
	);

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hsv_to_grb_8bit_top
// Drives hsv words through a table of corner pixels and then random pixels,
// with bursty valid and a stalling receiver. Each grb word is checked against
// its row's typed result or a behavioral hsv to grb conversion in the bench.
// ----------------------------------------------------------------------------

module testbench;

	localparam int unsigned DIV_43      = 43;
	localparam int unsigned DIV_42      = 42;
	localparam int unsigned FULL_SCALE  = 255;
	localparam int          RANDOM_PIX  = 1800;
	localparam int          DRAIN_CYC   = 20;
	localparam int          QUIET_LIMIT = 2000;
	localparam int          MAX_PRINTS  = 40;
	localparam int          N_ROWS      = 23;

	typedef struct packed {
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
	} grb_word_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
		logic       typed;
		grb_word_t  want;
	} pix_row_t;

	typedef enum int {SINK_OPEN, SINK_HALF, SINK_SLOW, SINK_BUSY} sink_mode_t;

	logic clk;
	logic arst_n;

	hsvg_pix_if pix_ch ();
	hsvg_grb_if grb_ch ();

	hsv_to_grb_8bit_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.grb    (grb_ch)
	);

	pix_row_t   stim_table [0:N_ROWS-1];
	pix_row_t   sent_pix_q [$];
	grb_word_t  expected_grb_q [$];
	sink_mode_t sink_mode;
	int         n_fail;
	int         n_sent;
	int         n_grey;
	int         n_checked;
	int         quiet_cycles;
	int         burst_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic grb_word_t hsv_to_grb(input logic [7:0] h, input logic [7:0] s,
		input logic [7:0] v);
		int unsigned hue_u;
		int unsigned chroma;
		int unsigned base;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		grb_word_t   px;
		hue_u = {24'd0, h};
		r = 0;
		g = 0;
		b = 0;
		if (s == 8'd0) begin
			r = {24'd0, v};
			g = {24'd0, v};
			b = {24'd0, v};
		end else begin
			chroma = (int'(v) * int'(s)) / FULL_SCALE;
			base = int'(v) - chroma;
			if (hue_u <= hsvg_pkg::HUE_END_0) begin
				r = chroma;
				g = (chroma * hue_u) / DIV_43;
			end else if (hue_u <= hsvg_pkg::HUE_END_1) begin
				r = (chroma * (hsvg_pkg::HUE_END_1 - hue_u)) / DIV_42;
				g = chroma;
			end else if (hue_u <= hsvg_pkg::HUE_END_2) begin
				g = chroma;
				b = (chroma * (hue_u - hsvg_pkg::HUE_START_2)) / DIV_43;
			end else if (hue_u <= hsvg_pkg::HUE_END_3) begin
				g = (chroma * (hsvg_pkg::HUE_END_3 - hue_u)) / DIV_43;
				b = chroma;
			end else if (hue_u <= hsvg_pkg::HUE_END_4) begin
				r = (chroma * (hue_u - hsvg_pkg::HUE_START_4)) / DIV_42;
				b = chroma;
			end else begin
				r = chroma;
				b = (chroma * (hsvg_pkg::HUE_END_5 - hue_u)) / DIV_43;
			end
			r += base;
			g += base;
			b += base;
		end
		px.green = g[7:0];
		px.red   = r[7:0];
		px.blue  = b[7:0];
		return px;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (n_fail < MAX_PRINTS)
			$display("error: %s got %0d want %0d (word %0d)", what, got, want, n_checked);
		n_fail++;
	endtask

	// corner pixels; typed rows carry their result, the others use hsv_to_grb
	initial begin
		stim_table = '{
			'{8'd100, 8'd0,   8'd200, 1'b1, '{8'd200, 8'd200, 8'd200}},
			'{8'd255, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
			'{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
			'{8'd60,  8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
			'{8'd0,   8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
			'{8'd43,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
			'{8'd44,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd248, 8'd0}},
			'{8'd85,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
			'{8'd86,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
			'{8'd128, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd249}},
			'{8'd129, 8'd255, 8'd255, 1'b1, '{8'd249, 8'd0,   8'd255}},
			'{8'd171, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
			'{8'd172, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
			'{8'd213, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd248, 8'd255}},
			'{8'd214, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd243}},
			'{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
			'{8'd0,   8'd1,   8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{8'd200, 8'd255, 8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
			'{8'd171, 8'd128, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{8'd43,  8'd254, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{8'd85,  8'd200, 8'd77,  1'b0, '{8'd0,   8'd0,   8'd0}},
			'{8'd127, 8'd17,  8'd250, 1'b0, '{8'd0,   8'd0,   8'd0}},
			'{8'd254, 8'd99,  8'd31,  1'b0, '{8'd0,   8'd0,   8'd0}}
		};
	end

	// bursts of back-to-back words with random gaps; valid drops only in a gap
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				pix_ch.valid      <= 1'b0;
				pix_ch.hue        <= 8'($urandom);
				pix_ch.saturation <= 8'($urandom);
				pix_ch.brightness <= 8'($urandom);
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 150 : 16);
		end
		burst_left--;
	endtask

	task automatic send_pixel(input pix_row_t row);
		sent_pix_q.push_back(row);
		pix_ch.valid      <= 1'b1;
		pix_ch.hue        <= row.hue;
		pix_ch.saturation <= row.saturation;
		pix_ch.brightness <= row.brightness;
		do
			@(posedge clk);
		while (!(pix_ch.valid && pix_ch.ready));
	endtask

	function automatic logic [7:0] pick_hue();
		logic [7:0] edge_hue;
		case ($urandom_range(0, 7))
			0: edge_hue = hsvg_pkg::HUE_END_0;
			1: edge_hue = hsvg_pkg::HUE_END_1;
			2: edge_hue = hsvg_pkg::HUE_END_2;
			3: edge_hue = hsvg_pkg::HUE_END_3;
			4: edge_hue = hsvg_pkg::HUE_END_4;
			5: edge_hue = hsvg_pkg::HUE_START_2;
			6: edge_hue = hsvg_pkg::HUE_START_4;
			default: edge_hue = hsvg_pkg::HUE_END_5;
		endcase
		// land on, just below or just past a sector edge (wraps to 0 above 255)
		return edge_hue + 8'($urandom_range(0, 2)) - 8'd1;
	endfunction

	initial begin
		pix_row_t row;
		arst_n            <= 1'b0;
		pix_ch.valid      <= 1'b0;
		pix_ch.hue        <= 8'd0;
		pix_ch.saturation <= 8'd0;
		pix_ch.brightness <= 8'd0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			pace_sender();
			send_pixel(stim_table[i]);
		end

		for (int i = 0; i < RANDOM_PIX; i++) begin
			row.hue        = 8'($urandom);
			row.saturation = 8'($urandom);
			row.brightness = 8'($urandom);
			row.typed      = 1'b0;
			row.want       = '0;
			case ($urandom_range(0, 9))
				0: row.saturation = 8'd0;
				1, 2: row.hue = pick_hue();
				3: begin
					row.hue = pick_hue();
					row.saturation = 8'd255;
					row.brightness = 8'd255;
				end
				4: row.brightness = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
				default: ;
			endcase
			pace_sender();
			send_pixel(row);
		end
		pix_ch.valid <= 1'b0;

		while (expected_grb_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("covered %0d pixels (%0d directed, %0d grey), %0d grb words checked",
			n_sent, N_ROWS, n_grey, n_checked);
		if (n_fail == 0 && expected_grb_q.size() == 0)
			$display("hsv_to_grb_8bit_top: match");
		else
			$display("hsv_to_grb_8bit_top: mismatch");
		$finish;
	end

	// receiver ready pattern, switching mode now and then
	always @(posedge clk) begin
		if (!arst_n) begin
			grb_ch.ready <= 1'b0;
			sink_mode = SINK_OPEN;
		end else begin
			if ($urandom_range(0, 99) == 0)
				sink_mode = sink_mode_t'($urandom_range(0, 3));
			case (sink_mode)
				SINK_OPEN: grb_ch.ready <= 1'b1;
				SINK_HALF: grb_ch.ready <= 1'($urandom_range(0, 1));
				SINK_SLOW: grb_ch.ready <= ($urandom_range(0, 3) == 0);
				default:   grb_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// accept side: queue the expected word; result side: compare with the oldest
	always @(posedge clk) begin
		pix_row_t  row;
		grb_word_t want;
		if (arst_n === 1'b1) begin
			quiet_cycles++;
			if (pix_ch.valid && pix_ch.ready) begin
				quiet_cycles = 0;
				row = sent_pix_q.pop_front();
				want = row.typed ? row.want
					: hsv_to_grb(pix_ch.hue, pix_ch.saturation, pix_ch.brightness);
				expected_grb_q.push_back(want);
				n_sent++;
				if (pix_ch.saturation == 8'd0)
					n_grey++;
			end
			if (grb_ch.valid && grb_ch.ready) begin
				quiet_cycles = 0;
				if (expected_grb_q.size() == 0) begin
					report_mismatch("unexpected word, green", int'(grb_ch.green), 0);
				end else begin
					want = expected_grb_q.pop_front();
					if (grb_ch.green !== want.green)
						report_mismatch("green", int'(grb_ch.green), int'(want.green));
					if (grb_ch.red !== want.red)
						report_mismatch("red", int'(grb_ch.red), int'(want.red));
					if (grb_ch.blue !== want.blue)
						report_mismatch("blue", int'(grb_ch.blue), int'(want.blue));
				end
				n_checked++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("hsv_to_grb_8bit_top: mismatch");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

endmodule
